FILE: rtl/mdp_pkg.sv
`timescale 1ns / 1ps

package mdp_pkg;

    localparam int OP_W   = 32;
    localparam int PROD_W = 2 * OP_W;
    localparam int MOD_W  = 33;
    localparam int REM_W  = MOD_W + 1;
    localparam int CNT_W  = 5;

    localparam logic [MOD_W-1:0] MOD_RESET = {1'b1, {OP_W{1'b0}}};

    typedef logic [OP_W-1:0]   word_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [MOD_W-1:0]  mod_t;
    typedef logic [REM_W-1:0]  rem_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam cnt_t CNT_LAST = '1;

endpackage

FILE: rtl/mdp_mul.sv
`timescale 1ns / 1ps

module mdp_mul (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  mdp_pkg::word_t   mult_a,
    input  mdp_pkg::word_t   mult_b,
    input  mdp_pkg::word_t   addend,
    output logic             done,
    output mdp_pkg::prod_t   product
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    mdp_pkg::cnt_t                 cnt_reg, cnt_next;
    mdp_pkg::word_t                hi_reg, hi_next;
    mdp_pkg::word_t                lo_reg, lo_next;
    mdp_pkg::word_t                b_reg, b_next;
    logic [mdp_pkg::OP_W:0]        psum;

    always_comb begin
        psum      = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, b_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        b_next    = b_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            hi_next   = addend;
            lo_next   = mult_a;
            b_next    = mult_b;
        end else if (busy_reg) begin
            // shift one multiplier bit out, one product bit in
            {hi_next, lo_next} = {psum, lo_reg[mdp_pkg::OP_W-1:1]};
            cnt_next           = cnt_reg + 1'b1;
            if (cnt_reg == mdp_pkg::CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        b_reg  <= b_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

FILE: rtl/mdp_red.sv
`timescale 1ns / 1ps

module mdp_red (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  mdp_pkg::prod_t   value,
    input  mdp_pkg::mod_t    modulus,
    output logic             done,
    output mdp_pkg::word_t   remainder
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    mdp_pkg::cnt_t   cnt_reg, cnt_next;
    mdp_pkg::prod_t  val_reg, val_next;
    mdp_pkg::rem_t   rem_reg, rem_next;
    mdp_pkg::rem_t   rem_mid;

    function automatic mdp_pkg::rem_t red_step(mdp_pkg::rem_t r, logic b, mdp_pkg::mod_t q);
        mdp_pkg::rem_t t;
        t = {r[mdp_pkg::REM_W-2:0], b};
        if ((q != '0) && (t >= {1'b0, q})) begin
            t = t - {1'b0, q};
        end
        return t;
    endfunction

    always_comb begin
        rem_mid   = red_step(rem_reg, val_reg[mdp_pkg::PROD_W-1], modulus);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = value;
            rem_next  = '0;
        end else if (busy_reg) begin
            // two restoring steps per cycle, most significant bits first
            rem_next = red_step(rem_mid, val_reg[mdp_pkg::PROD_W-2], modulus);
            val_next = {val_reg[mdp_pkg::PROD_W-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mdp_pkg::CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[mdp_pkg::OP_W-1:0];

endmodule

FILE: rtl/modular_dot_product.sv
`timescale 1ns / 1ps
// Streaming modular multiply-accumulate.
// Input channel (s_valid/s_ready): one operand pair per beat, s_last_pair
// closes a dot product. Result channel (m_valid/m_ready): one beat per
// closed dot product, carrying the sum of products modulo the modulus.
// Configuration channel (cfg_valid/cfg_ready): writes the 33-bit modulus;
// cfg_ready is always high. Write it only while the block is idle.
// s_ready drops once a pair is taken and rises again after its write-back, so
// a new pair is taken only when the last one is through: it passes the
// bit-serial shift-add multiplier (which also folds in the running sum), the
// restoring reducer at two bits per cycle, and then write-back.
// m_valid rises as the last pair of a dot product leaves write-back.
// The result sits in an output register, so the next pair is taken while it
// waits; a later last pair holds in write-back until the register frees up.
// Reset clears the running sum, sets the modulus to 2^32 and drops m_valid.
// A modulus of zero wraps the sum at 32 bits.

module modular_dot_product (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [31:0]              s_first_operand,
    input  logic [31:0]              s_second_operand,
    input  logic                     s_last_pair,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [31:0]              m_dot_result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [32:0]              cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    logic [1:0]      state_reg, state_next;
    mdp_pkg::mod_t   mod_reg;
    mdp_pkg::word_t  sum_reg, sum_next;
    logic            last_reg;
    logic            m_valid_reg, m_valid_next;
    mdp_pkg::word_t  m_data_reg, m_data_next;

    logic            s_beat;
    logic            mul_done;
    mdp_pkg::prod_t  mul_prod;
    logic            red_done;
    mdp_pkg::word_t  red_rem;
    logic            wb_ok;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_beat    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    mdp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_beat),
        .mult_a  (s_first_operand),
        .mult_b  (s_second_operand),
        .addend  (sum_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    mdp_red u_red (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mul_done),
        .value     (mul_prod),
        .modulus   (mod_reg),
        .done      (red_done),
        .remainder (red_rem)
    );

    assign wb_ok = !last_reg || !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_RED;
                end
            end
            ST_RED: begin
                if (red_done) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                // a last pair holds until the output register can take a new beat
                if (wb_ok) begin
                    state_next = ST_IDLE;
                    if (last_reg) begin
                        sum_next     = '0;
                        m_valid_next = 1'b1;
                        m_data_next  = red_rem;
                    end else begin
                        sum_next = red_rem;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mod_reg     <= mdp_pkg::MOD_RESET;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                mod_reg <= cfg_data;
            end
        end
        m_data_reg <= m_data_next;
        if (s_beat) begin
            last_reg <= s_last_pair;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_dot_result = m_data_reg;

endmodule
